@@ design/lpfr_pkg.sv @@
// Package for the LRU page frame replacer: field widths, register map and reset values.
// Used by the interfaces and by every module of the block.
package lpfr_pkg;

  localparam int PAGE_W          = 16;
  localparam int FRAME_IDX_W     = 4;
  localparam int FAULT_W         = 32;
  localparam int CFG_W           = 5;
  localparam int APB_DATA_W      = 32;
  localparam int APB_ADDR_W      = 3;
  localparam int FRAMES_DEFAULT  = 16;
  localparam int TIME_BITS_DEFAULT = 32;

  localparam logic [APB_ADDR_W-3:0] REG_FRAME_COUNT   = 1'b0;
  localparam logic [CFG_W-1:0]      FRAME_COUNT_RESET = 5'd16;
  localparam logic [FAULT_W-1:0]    FAULT_MAX         = {FAULT_W{1'b1}};

endpackage

@@ design/lpfr_if.sv @@
// Valid/ready channel interfaces for page references and replacement results.
// Depends on lpfr_pkg for the payload widths.
interface lpfr_req_if;
  logic                          valid;
  logic                          ready;
  logic [lpfr_pkg::PAGE_W-1:0]   page_number;
  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
endinterface

interface lpfr_res_if;
  logic                             valid;
  logic                             ready;
  logic                             hit;
  logic [lpfr_pkg::FRAME_IDX_W-1:0] frame_index;
  logic                             evicted_valid;
  logic [lpfr_pkg::PAGE_W-1:0]      evicted_page;
  logic [lpfr_pkg::FAULT_W-1:0]     fault_total;
  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input frame_index, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

@@ design/lpfr_apb_regs.sv @@
// APB-style configuration register: holds frame_count and flags each write of it.
// Depends on lpfr_pkg for the register map and reset value.
module lpfr_apb_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lpfr_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [lpfr_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [lpfr_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  output logic [lpfr_pkg::CFG_W-1:0]          frame_count,
  output logic                                cfg_wr
);

  logic hit_reg;

  assign pready  = 1'b1;
  assign hit_reg = (paddr[lpfr_pkg::APB_ADDR_W-1:2] == lpfr_pkg::REG_FRAME_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && hit_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= lpfr_pkg::FRAME_COUNT_RESET;
    end else if (cfg_wr) begin
      frame_count <= pwdata[lpfr_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit_reg) begin
      prdata = lpfr_pkg::APB_DATA_W'(frame_count);
    end
  end

endmodule

@@ design/lpfr_frame_store.sv @@
// Frame store: page and last-use memories with registered read, valid bits in flops.
// Depends on lpfr_pkg for the page width.
module lpfr_frame_store #(
  parameter int FRAMES    = lpfr_pkg::FRAMES_DEFAULT,
  parameter int TIME_BITS = lpfr_pkg::TIME_BITS_DEFAULT,
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        clear_all,
  input  logic [IDX_W-1:0]            rd_addr,
  output logic                        rd_valid,
  output logic [lpfr_pkg::PAGE_W-1:0] rd_page,
  output logic [TIME_BITS-1:0]        rd_time,
  input  logic [IDX_W-1:0]            wr_addr,
  input  logic                        wr_time_en,
  input  logic [TIME_BITS-1:0]        wr_time,
  input  logic                        wr_page_en,
  input  logic [lpfr_pkg::PAGE_W-1:0] wr_page
);

  logic [lpfr_pkg::PAGE_W-1:0] page_mem [FRAMES];
  logic [TIME_BITS-1:0]        time_mem [FRAMES];
  logic [FRAMES-1:0]           valid;

  always_ff @(posedge clk) begin
    if (wr_page_en) begin
      page_mem[wr_addr] <= wr_page;
    end
    if (wr_time_en) begin
      time_mem[wr_addr] <= wr_time;
    end
    rd_page <= page_mem[rd_addr];
    rd_time <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || clear_all) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_page_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

@@ design/lpfr_scan_unit.sv @@
// Scan unit: one frame a cycle, tracks first match, first free frame and oldest frame.
// Depends on lpfr_pkg for the page width.
module lpfr_scan_unit #(
  parameter int FRAMES    = lpfr_pkg::FRAMES_DEFAULT,
  parameter int TIME_BITS = lpfr_pkg::TIME_BITS_DEFAULT,
  localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        cmp_en,
  input  logic [IDX_W-1:0]            cmp_idx,
  input  logic [lpfr_pkg::PAGE_W-1:0] ref_page,
  input  logic                        rd_valid,
  input  logic [lpfr_pkg::PAGE_W-1:0] rd_page,
  input  logic [TIME_BITS-1:0]        rd_time,
  output logic                        hit,
  output logic                        evict,
  output logic [IDX_W-1:0]            slot,
  output logic [lpfr_pkg::PAGE_W-1:0] evict_page
);

  logic                        found;
  logic                        have_free;
  logic                        min_seen;
  logic [IDX_W-1:0]            match_idx;
  logic [IDX_W-1:0]            free_idx;
  logic [IDX_W-1:0]            min_idx;
  logic [TIME_BITS-1:0]        min_time;
  logic [lpfr_pkg::PAGE_W-1:0] min_page;
  logic                        older;

  assign older = !min_seen || (rd_time < min_time);

  always_ff @(posedge clk) begin
    if (rst || start) begin
      found     <= 1'b0;
      have_free <= 1'b0;
      min_seen  <= 1'b0;
    end else if (cmp_en) begin
      if (rd_valid && (rd_page == ref_page) && !found) begin
        found <= 1'b1;
      end
      if (!rd_valid && !have_free) begin
        have_free <= 1'b1;
      end
      if (rd_valid && older) begin
        min_seen <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      if (rd_valid && (rd_page == ref_page) && !found) begin
        match_idx <= cmp_idx;
      end
      if (!rd_valid && !have_free) begin
        free_idx <= cmp_idx;
      end
      if (rd_valid && older) begin
        min_idx  <= cmp_idx;
        min_time <= rd_time;
        min_page <= rd_page;
      end
    end
  end

  always_comb begin
    hit        = found;
    evict      = !found && !have_free;
    evict_page = min_page;
    if (found) begin
      slot = match_idx;
    end else if (have_free) begin
      slot = free_idx;
    end else begin
      slot = min_idx;
    end
  end

endmodule

@@ design/lru_page_frame_replacer_top.sv @@
// Top level of the LRU page frame replacer: sequencer, counters and result register.
// Depends on lpfr_pkg, lpfr_if, lpfr_apb_regs, lpfr_frame_store and lpfr_scan_unit.
//
// Usage: each transaction on req carries one page_number; each transaction on res
// returns hit, frame_index, evicted_valid, evicted_page and fault_total for it, in order.
// req.ready is high only while the sequencer is idle. After acceptance the block reads
// the frame store one frame a cycle over the active frame count N, compares in the
// following cycle, then writes the chosen frame and loads the result register.
// Frames pass one by one through the single memory read port and the shared compare of
// the scan unit; the next item is accepted in the cycle after the result is loaded, so a
// new item is never taken while the last one is still being scanned or written.
// When the receiver stalls, the result holds in its register and the next item is still
// accepted and scanned; it waits in the write step until the register is free.
// Reset empties all frames, clears the time and fault counters and sets frame_count to
// 16. A write of frame_count over APB (address 0) empties all frames and clears both
// counters at once; write it only while the block is idle.
module lru_page_frame_replacer_top #(
  parameter int FRAMES    = lpfr_pkg::FRAMES_DEFAULT,
  parameter int TIME_BITS = lpfr_pkg::TIME_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  lpfr_req_if.sink                          req,
  lpfr_res_if.source                        res,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [lpfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [lpfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [lpfr_pkg::CFG_W-1:0]    frame_count;
  logic                          cfg_wr;
  logic [CNT_W-1:0]              active_count;
  logic [IDX_W-1:0]              last_idx;
  logic [IDX_W-1:0]              scan_idx;
  logic                          issue_done;
  logic                          issue;
  logic                          cmp_en;
  logic [IDX_W-1:0]              cmp_idx;
  logic                          cmp_last;
  logic [lpfr_pkg::PAGE_W-1:0]   page_reg;
  logic [TIME_BITS-1:0]          request_time;
  logic [lpfr_pkg::FAULT_W-1:0]  fault_count;
  logic [lpfr_pkg::FAULT_W-1:0]  fault_next;
  logic                          accept;
  logic                          commit;
  logic                          rd_valid;
  logic [lpfr_pkg::PAGE_W-1:0]   rd_page;
  logic [TIME_BITS-1:0]          rd_time;
  logic                          scan_hit;
  logic                          scan_evict;
  logic [IDX_W-1:0]              scan_slot;
  logic [lpfr_pkg::PAGE_W-1:0]   scan_evict_page;
  logic                          out_valid;
  logic                          out_hit;
  logic [lpfr_pkg::FRAME_IDX_W-1:0] out_frame_index;
  logic                          out_evicted_valid;
  logic [lpfr_pkg::PAGE_W-1:0]   out_evicted_page;
  logic [lpfr_pkg::FAULT_W-1:0]  out_fault_total;

  lpfr_apb_regs u_regs (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .frame_count (frame_count),
    .cfg_wr      (cfg_wr)
  );

  always_comb begin
    if (frame_count == '0) begin
      active_count = CNT_W'(1);
    end else if (32'(frame_count) > FRAMES) begin
      active_count = CNT_W'(FRAMES);
    end else begin
      active_count = CNT_W'(frame_count);
    end
  end

  assign last_idx = IDX_W'(active_count - CNT_W'(1));
  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign issue    = (state == S_SCAN) && !issue_done;
  assign commit   = (state == S_WRITE) && (!out_valid || res.ready);

  lpfr_frame_store #(
    .FRAMES    (FRAMES),
    .TIME_BITS (TIME_BITS)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .clear_all  (cfg_wr),
    .rd_addr    (scan_idx),
    .rd_valid   (rd_valid),
    .rd_page    (rd_page),
    .rd_time    (rd_time),
    .wr_addr    (scan_slot),
    .wr_time_en (commit),
    .wr_time    (request_time),
    .wr_page_en (commit && !scan_hit),
    .wr_page    (page_reg)
  );

  lpfr_scan_unit #(
    .FRAMES    (FRAMES),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .cmp_en     (cmp_en),
    .cmp_idx    (cmp_idx),
    .ref_page   (page_reg),
    .rd_valid   (rd_valid),
    .rd_page    (rd_page),
    .rd_time    (rd_time),
    .hit        (scan_hit),
    .evict      (scan_evict),
    .slot       (scan_slot),
    .evict_page (scan_evict_page)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmp_en && cmp_last) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        if (commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    fault_next = fault_count;
    if (!scan_hit && (fault_count != lpfr_pkg::FAULT_MAX)) begin
      fault_next = fault_count + lpfr_pkg::FAULT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_idx     <= '0;
      issue_done   <= 1'b0;
      cmp_en       <= 1'b0;
      cmp_last     <= 1'b0;
      request_time <= '0;
      fault_count  <= '0;
      out_valid    <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= issue;
      if (accept) begin
        scan_idx   <= '0;
        issue_done <= 1'b0;
      end else if (issue) begin
        if (scan_idx == last_idx) begin
          issue_done <= 1'b1;
        end else begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
      end
      cmp_last <= (scan_idx == last_idx);
      if (cfg_wr) begin
        request_time <= '0;
        fault_count  <= '0;
      end else if (commit) begin
        fault_count <= fault_next;
        if (request_time != TIME_MAX) begin
          request_time <= request_time + TIME_BITS'(1);
        end
      end
      if (commit) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      page_reg <= req.page_number;
    end
    cmp_idx <= scan_idx;
    if (commit) begin
      out_hit           <= scan_hit;
      out_frame_index   <= lpfr_pkg::FRAME_IDX_W'(scan_slot);
      out_evicted_valid <= scan_evict;
      out_evicted_page  <= scan_evict ? scan_evict_page : '0;
      out_fault_total   <= fault_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.hit           = out_hit;
  assign res.frame_index   = out_frame_index;
  assign res.evicted_valid = out_evicted_valid;
  assign res.evicted_page  = out_evicted_page;
  assign res.fault_total   = out_fault_total;

  a_fault_monotone: assert property (@(posedge clk) disable iff (rst)
    (!rst && !cfg_wr) |=> (fault_count >= $past(fault_count)))
    else $error("fault counter went backwards without a reconfiguration");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_hit && out_evicted_valid))
    else $error("result reports both a hit and an eviction");

  a_evict_page_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_evicted_valid) |-> (out_evicted_page == '0))
    else $error("evicted page not zero without an eviction");

  a_commit_after_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && (state_next == S_WRITE)) |-> (issue_done && cmp_last))
    else $error("write step entered before the last frame was compared");

endmodule
